### hw/rtl/fsp_pkg.sv
// fsp_pkg: shared types and constants for the pixel stream frame parser.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package fsp_pkg;

  localparam int unsigned AddrW  = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned LedW   = 11;

  localparam logic [ByteW-1:0] CmdPixels  = 8'd0;
  localparam logic [ByteW-1:0] CmdSysex   = 8'd255;
  localparam logic [ByteW-1:0] MaxChannel = 8'd1;

  localparam logic [AddrW-1:0] MaxBytesReset = 12'd1536;
  localparam logic [AddrW-1:0] MinLimit      = 12'd3;
  localparam logic [AddrW-1:0] AddrMax       = 12'd4095;

  // floor(x / 3) = (x * 2731) >> 13 for any 12-bit x
  localparam logic [2*AddrW-1:0] DivThreeMul   = 24'd2731;
  localparam int unsigned        DivThreeShift = 13;

  localparam int unsigned QueueDepth = 2;

  // one-hot parser modes
  typedef enum logic [2:0] {
    ModeHeader  = 3'b001,
    ModeData    = 3'b010,
    ModeDiscard = 3'b100
  } fsp_mode_e;

  typedef enum logic [1:0] {
    HdrChannel = 2'd0,
    HdrCommand = 2'd1,
    HdrLenHigh = 2'd2,
    HdrLenLow  = 2'd3
  } fsp_hdr_e;

  // classified item handed from front to back
  typedef struct packed {
    logic             wr_valid;
    logic [AddrW-1:0] wr_addr;
    logic [ByteW-1:0] wr_data;
    logic             commit;
    logic [AddrW-1:0] total;
    logic             sysex;
    logic             rejected;
  } fsp_op_t;

endpackage

`default_nettype wire

### hw/rtl/fsp_if.sv
// fsp_if: valid/ready channel interfaces for the stream byte input and the
// parser result output. Depends on nothing.
`default_nettype none

interface fsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fsp_result_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [11:0] write_addr;
  logic [7:0]  write_data;
  logic        frame_commit;
  logic [10:0] led_count;
  logic        sysex_done;
  logic        header_rejected;

  modport source (output valid, output write_valid, output write_addr, output write_data,
                  output frame_commit, output led_count, output sysex_done,
                  output header_rejected, input ready);
  modport sink   (input valid, input write_valid, input write_addr, input write_data,
                  input frame_commit, input led_count, input sysex_done,
                  input header_rejected, output ready);
endinterface

`default_nettype wire

### hw/rtl/fsp_front.sv
// fsp_front: header parser and payload/discard sequencer; classifies each
// stream byte into an fsp_op_t. Depends on fsp_pkg.
`default_nettype none

module fsp_front #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fsp_pkg::AddrW-1:0]  cfg_wdata_i,
  input  logic                       accept_i,
  input  logic [fsp_pkg::ByteW-1:0]  byte_i,
  output fsp_pkg::fsp_op_t           op_o
);
  import fsp_pkg::*;

  localparam int unsigned CapInt = (BUFFER_BYTES > 4095) ? 4095 : BUFFER_BYTES;
  localparam logic [AddrW-1:0] LimCap = AddrW'(CapInt);

  fsp_mode_e         mode_q, mode_d;
  fsp_hdr_e          hdr_q, hdr_d;
  logic [ByteW-1:0]  chan_q, chan_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [ByteW-1:0]  len_hi_q, len_hi_d;
  logic [AddrW-1:0]  rd_rem_q, rd_rem_d;
  logic [AddrW-1:0]  rd_total_q, rd_total_d;
  logic [LenW-1:0]   disc_q, disc_d;
  logic [AddrW-1:0]  wr_idx_q, wr_idx_d;
  logic [AddrW-1:0]  max_bytes_q;

  logic [AddrW-1:0]  lim;
  logic [LenW-1:0]   len;
  logic              hdr_ok;

  always_comb begin
    lim = (max_bytes_q > LimCap) ? LimCap : max_bytes_q;
    if (lim < MinLimit) begin
      lim = MinLimit;
    end
  end

  assign len    = {len_hi_q, byte_i};
  assign hdr_ok = (chan_q <= MaxChannel) && (cmd_q == CmdPixels || cmd_q == CmdSysex);

  always_comb begin
    mode_d     = mode_q;
    hdr_d      = hdr_q;
    chan_d     = chan_q;
    cmd_d      = cmd_q;
    len_hi_d   = len_hi_q;
    rd_rem_d   = rd_rem_q;
    rd_total_d = rd_total_q;
    disc_d     = disc_q;
    wr_idx_d   = wr_idx_q;
    op_o       = '0;

    case (mode_q)
      ModeData: begin
        op_o.wr_valid = 1'b1;
        op_o.wr_addr  = wr_idx_q;
        op_o.wr_data  = byte_i;
        if (rd_rem_q <= AddrW'(1)) begin
          rd_rem_d = '0;
          if (cmd_q == CmdPixels) begin
            op_o.commit = 1'b1;
            op_o.total  = rd_total_q;
          end else if (cmd_q == CmdSysex) begin
            op_o.sysex = 1'b1;
          end
          wr_idx_d = '0;
          mode_d   = (disc_q != '0) ? ModeDiscard : ModeHeader;
        end else begin
          rd_rem_d = rd_rem_q - AddrW'(1);
          wr_idx_d = wr_idx_q + AddrW'(1);
        end
      end
      ModeDiscard: begin
        if (disc_q <= LenW'(1)) begin
          disc_d = '0;
          mode_d = ModeHeader;
        end else begin
          disc_d = disc_q - LenW'(1);
        end
      end
      default: begin
        mode_d = ModeHeader;
        case (hdr_q)
          HdrChannel: begin
            chan_d = byte_i;
            hdr_d  = HdrCommand;
          end
          HdrCommand: begin
            cmd_d = byte_i;
            hdr_d = HdrLenHigh;
          end
          HdrLenHigh: begin
            len_hi_d = byte_i;
            hdr_d    = HdrLenLow;
          end
          default: begin
            hdr_d    = HdrChannel;
            wr_idx_d = '0;
            if (len != '0) begin
              if (hdr_ok) begin
                mode_d = ModeData;
                if (len <= {{(LenW-AddrW){1'b0}}, lim}) begin
                  rd_rem_d = len[AddrW-1:0];
                  disc_d   = '0;
                end else begin
                  rd_rem_d = lim;
                  disc_d   = len - {{(LenW-AddrW){1'b0}}, lim};
                end
                rd_total_d = rd_rem_d;
              end else begin
                op_o.rejected = 1'b1;
                mode_d        = ModeDiscard;
                disc_d        = len;
                rd_rem_d      = '0;
              end
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeHeader;
      hdr_q       <= HdrChannel;
      chan_q      <= '0;
      cmd_q       <= '0;
      len_hi_q    <= '0;
      rd_rem_q    <= '0;
      rd_total_q  <= '0;
      disc_q      <= '0;
      wr_idx_q    <= '0;
      max_bytes_q <= MaxBytesReset;
    end else begin
      if (cfg_we_i) begin
        max_bytes_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        mode_q     <= mode_d;
        hdr_q      <= hdr_d;
        chan_q     <= chan_d;
        cmd_q      <= cmd_d;
        len_hi_q   <= len_hi_d;
        rd_rem_q   <= rd_rem_d;
        rd_total_q <= rd_total_d;
        disc_q     <= disc_d;
        wr_idx_q   <= wr_idx_d;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fsp_queue.sv
// fsp_queue: two-entry FIFO of classified items between front and back.
// Depends on fsp_pkg.
`default_nettype none

module fsp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fsp_pkg::fsp_op_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output fsp_pkg::fsp_op_t  head_o,
  output logic              empty_o
);
  import fsp_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  fsp_op_t          mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fsp_back.sv
// fsp_back: result stage; turns a classified item into the output fields
// (pixel count via reciprocal multiply) and holds it in the output register.
// Depends on fsp_pkg and fsp_if.
`default_nettype none

module fsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  fsp_pkg::fsp_op_t  head_i,
  output logic              pop_o,
  fsp_result_if.source      res
);
  import fsp_pkg::*;

  logic              out_valid_q;
  logic [2*AddrW-1:0] prod;
  logic              wr_valid_q, commit_q, sysex_q, rejected_q;
  logic [AddrW-1:0]  wr_addr_q;
  logic [ByteW-1:0]  wr_data_q;
  logic [LedW-1:0]   led_q;

  assign pop_o = !empty_i && (!out_valid_q || res.ready);
  assign prod  = {{AddrW{1'b0}}, head_i.total} * DivThreeMul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      wr_valid_q <= head_i.wr_valid;
      wr_addr_q  <= head_i.wr_addr;
      wr_data_q  <= head_i.wr_data;
      commit_q   <= head_i.commit;
      // total is zero unless commit is set
      led_q      <= prod[DivThreeShift +: LedW];
      sysex_q    <= head_i.sysex;
      rejected_q <= head_i.rejected;
    end
  end

  assign res.valid           = out_valid_q;
  assign res.write_valid     = wr_valid_q;
  assign res.write_addr      = wr_addr_q;
  assign res.write_data      = wr_data_q;
  assign res.frame_commit    = commit_q;
  assign res.led_count       = led_q;
  assign res.sysex_done      = sysex_q;
  assign res.header_rejected = rejected_q;

endmodule

`default_nettype wire

### hw/rtl/pixel_stream_frame_parser.sv
// pixel_stream_frame_parser: top level; front parser, item queue and result
// stage. Depends on fsp_pkg, fsp_if, fsp_front, fsp_queue, fsp_back.
//
//   port      dir  handshake      contents
//   in_byte   in   valid/ready    data_byte
//   out_res   out  valid/ready    write_*, frame_commit, led_count, sysex_done,
//                                 header_rejected (one result per item)
//   cfg_*     in   write enable   max_bytes
//
// One item per cycle sustained while out_res does not stall; an item passes
// through a queue entry, then the output register. The front's parser state
// register sets the rate; bytes are classified combinationally. in_byte.ready
// drops only when the two-entry queue is full, i.e. when out_res has stalled.
// Reset is asynchronous: header mode, max_bytes at 1536, no clearing pass.
`default_nettype none

module pixel_stream_frame_parser #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fsp_pkg::AddrW-1:0] cfg_wdata_i,
  fsp_byte_if.sink                  in_byte,
  fsp_result_if.source              out_res
);
  import fsp_pkg::*;

  fsp_op_t op, head;
  logic    accept, full, empty, pop;

  assign in_byte.ready = !full;
  assign accept        = in_byte.valid && !full;

  fsp_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .byte_i     (in_byte.data_byte),
    .op_o       (op)
  );

  fsp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(op),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  fsp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .head_i (head),
    .pop_o  (pop),
    .res    (out_res)
  );

endmodule

`default_nettype wire
